@@ rtl/lsra_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants, types and helpers of the linear scan register allocator.
// No dependencies; every other rtl file imports it.
package lsra_pkg;

    localparam int REG_SLOTS = 8;
    localparam int NSLOTS    = REG_SLOTS - 1;
    localparam int SLOT_W    = (NSLOTS > 1) ? $clog2(NSLOTS) : 1;
    localparam int DATA_W    = 16;
    localparam int REG_W     = 3;

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NSLOTS - 1);
    localparam logic [REG_W-1:0]  SPILL_REG = REG_W'(REG_SLOTS - 1);

    typedef struct packed {
        logic              we;
        logic [SLOT_W-1:0] addr;
        logic [DATA_W-1:0] owner;
        logic [DATA_W-1:0] last_use;
    } t_slot_wr;

    typedef struct packed {
        logic free;
        logic better;
    } t_scan_res;

    function automatic logic [REG_W-1:0] slot_to_reg(input logic [SLOT_W-1:0] slot);
        logic [31:0] wide;
        wide = 32'(slot);
        return wide[REG_W-1:0];
    endfunction

endpackage

@@ rtl/linear_scan_register_allocator.sv @@
`timescale 1ns / 1ps
// Top level: sequencer, scan state and result register of the allocator.
// Depends on lsra_pkg, lsra_slot_file and lsra_scan.
//
//   channel  handshake          payload
//   in       i_valid / o_ready  i_interval_id, i_def_point, i_end_point
//   out      o_valid / i_ready  o_assigned_reg, o_self_spilled, o_victim_valid, o_victim_id
//
// An item is accepted in ST_IDLE, then ST_SCAN reads up to NSLOTS slots in order,
// stopping at the first free one: the slot file's single read port sees one slot a cycle.
// Reset clears all busy flags at once; no clearing pass.
// A finished beat waits in the result register; the scan holds on its deciding
// step only while that register is full and not taken.
module linear_scan_register_allocator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [15:0] i_interval_id,
    input  logic [15:0] i_def_point,
    input  logic [15:0] i_end_point,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_assigned_reg,
    output logic        o_self_spilled,
    output logic        o_victim_valid,
    output logic [15:0] o_victim_id
);
    import lsra_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic              r_state, n_state;
    logic [DATA_W-1:0] r_id, r_def, r_end;
    logic [SLOT_W-1:0] r_idx, n_idx;
    logic [SLOT_W-1:0] r_best_idx, n_best_idx;
    logic [DATA_W-1:0] r_best_end, n_best_end;
    logic [DATA_W-1:0] r_best_owner, n_best_owner;

    logic              r_o_valid, n_o_valid;
    logic [REG_W-1:0]  r_o_reg, n_o_reg;
    logic              r_o_self, n_o_self;
    logic              r_o_vv, n_o_vv;
    logic [DATA_W-1:0] r_o_vid, n_o_vid;

    logic              rd_busy;
    logic [DATA_W-1:0] rd_owner, rd_last_use;
    t_slot_wr          wr;
    t_scan_res         scan;

    logic              out_free;
    logic              step_last;
    logic [SLOT_W-1:0] cand_idx;
    logic [DATA_W-1:0] cand_end, cand_owner;

    lsra_slot_file u_slot_file (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_rd_addr     (r_idx),
        .i_wr          (wr),
        .o_rd_busy     (rd_busy),
        .o_rd_owner    (rd_owner),
        .o_rd_last_use (rd_last_use)
    );

    lsra_scan u_scan (
        .i_first    (r_idx == '0),
        .i_busy     (rd_busy),
        .i_last_use (rd_last_use),
        .i_def      (r_def),
        .i_best_end (r_best_end),
        .o_res      (scan)
    );

    assign o_ready   = (r_state == ST_IDLE);
    assign out_free  = !r_o_valid || i_ready;
    assign step_last = (r_idx == LAST_SLOT);

    assign cand_idx   = scan.better ? r_idx       : r_best_idx;
    assign cand_end   = scan.better ? rd_last_use : r_best_end;
    assign cand_owner = scan.better ? rd_owner    : r_best_owner;

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_best_idx   = r_best_idx;
        n_best_end   = r_best_end;
        n_best_owner = r_best_owner;
        n_o_valid    = r_o_valid && !i_ready;
        n_o_reg      = r_o_reg;
        n_o_self     = r_o_self;
        n_o_vv       = r_o_vv;
        n_o_vid      = r_o_vid;
        wr.we        = 1'b0;
        wr.addr      = r_idx;
        wr.owner     = r_id;
        wr.last_use  = r_end;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = ST_SCAN;
                    n_idx   = '0;
                end
            end
            ST_SCAN: begin
                if (scan.free) begin
                    if (out_free) begin
                        wr.we     = 1'b1;
                        n_o_valid = 1'b1;
                        n_o_reg   = slot_to_reg(r_idx);
                        n_o_self  = 1'b0;
                        n_o_vv    = 1'b0;
                        n_o_vid   = '0;
                        n_state   = ST_IDLE;
                    end
                end else if (step_last) begin
                    if (out_free) begin
                        n_o_valid = 1'b1;
                        n_state   = ST_IDLE;
                        if (cand_end < r_end) begin
                            n_o_reg  = SPILL_REG;
                            n_o_self = 1'b1;
                            n_o_vv   = 1'b0;
                            n_o_vid  = '0;
                        end else begin
                            wr.we    = 1'b1;
                            wr.addr  = cand_idx;
                            n_o_reg  = slot_to_reg(cand_idx);
                            n_o_self = 1'b0;
                            n_o_vv   = 1'b1;
                            n_o_vid  = cand_owner;
                        end
                    end
                end else begin
                    n_best_idx   = cand_idx;
                    n_best_end   = cand_end;
                    n_best_owner = cand_owner;
                    n_idx        = r_idx + SLOT_W'(1);
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_id  <= i_interval_id;
            r_def <= i_def_point;
            r_end <= i_end_point;
        end
        r_idx        <= n_idx;
        r_best_idx   <= n_best_idx;
        r_best_end   <= n_best_end;
        r_best_owner <= n_best_owner;
        r_o_reg      <= n_o_reg;
        r_o_self     <= n_o_self;
        r_o_vv       <= n_o_vv;
        r_o_vid      <= n_o_vid;
    end

    assign o_valid        = r_o_valid;
    assign o_assigned_reg = r_o_reg;
    assign o_self_spilled = r_o_self;
    assign o_victim_valid = r_o_vv;
    assign o_victim_id    = r_o_vid;

endmodule

@@ rtl/lsra_slot_file.sv @@
`timescale 1ns / 1ps
// Register slot storage: busy flags, occupant ids and end points.
// One read port at the scan index, one write port. Depends on lsra_pkg.
module lsra_slot_file (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [lsra_pkg::SLOT_W-1:0]    i_rd_addr,
    input  lsra_pkg::t_slot_wr             i_wr,
    output logic                           o_rd_busy,
    output logic [lsra_pkg::DATA_W-1:0]    o_rd_owner,
    output logic [lsra_pkg::DATA_W-1:0]    o_rd_last_use
);
    import lsra_pkg::*;

    logic [NSLOTS-1:0] r_busy;
    logic [DATA_W-1:0] r_owner    [NSLOTS];
    logic [DATA_W-1:0] r_last_use [NSLOTS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= '0;
        end else if (i_wr.we) begin
            r_busy[i_wr.addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_owner[i_wr.addr]    <= i_wr.owner;
            r_last_use[i_wr.addr] <= i_wr.last_use;
        end
    end

    assign o_rd_busy     = r_busy[i_rd_addr];
    assign o_rd_owner    = r_owner[i_rd_addr];
    assign o_rd_last_use = r_last_use[i_rd_addr];

endmodule

@@ rtl/lsra_scan.sv @@
`timescale 1ns / 1ps
// Shared compare unit: free test and furthest-end test for one slot a cycle.
// Depends on lsra_pkg.
module lsra_scan (
    input  logic                        i_first,
    input  logic                        i_busy,
    input  logic [lsra_pkg::DATA_W-1:0] i_last_use,
    input  logic [lsra_pkg::DATA_W-1:0] i_def,
    input  logic [lsra_pkg::DATA_W-1:0] i_best_end,
    output lsra_pkg::t_scan_res         o_res
);
    import lsra_pkg::*;

    assign o_res.free   = !i_busy || (i_last_use <= i_def);
    assign o_res.better = i_first || (i_best_end < i_last_use);

endmodule

@@ verif/lsra_checker.sv @@
`timescale 1ns / 1ps
// Checker for the linear scan register allocator: watches both channels, predicts each beat.
// Depends on lsra_pkg for the slot count, field widths and spill register number.
module lsra_checker
    import lsra_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        o_ready,
    input  logic [15:0] i_interval_id,
    input  logic [15:0] i_def_point,
    input  logic [15:0] i_end_point,
    input  logic        o_valid,
    input  logic        i_ready,
    input  logic [2:0]  o_assigned_reg,
    input  logic        o_self_spilled,
    input  logic        o_victim_valid,
    input  logic [15:0] o_victim_id,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic [REG_W-1:0]  assigned;
        logic              self_spilled;
        logic              victim_valid;
        logic [DATA_W-1:0] victim_id;
    } t_alloc_result;

    logic              slot_live [NSLOTS];
    logic [DATA_W-1:0] slot_id   [NSLOTS];
    logic [DATA_W-1:0] slot_end  [NSLOTS];

    t_alloc_result expected_allocs [$];
    t_alloc_result want;
    int            failures = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic t_alloc_result allocate_interval(input logic [DATA_W-1:0] id,
                                                        input logic [DATA_W-1:0] def_pt,
                                                        input logic [DATA_W-1:0] end_pt);
        t_alloc_result     r;
        int                pick;
        int                best;
        logic [DATA_W-1:0] best_end;
        r    = '0;
        pick = -1;
        for (int s = 0; s < NSLOTS; s++) begin
            if (pick < 0 && (!slot_live[s] || slot_end[s] <= def_pt)) begin
                pick = s;
            end
        end
        if (pick >= 0) begin
            slot_live[pick] = 1'b1;
            slot_id[pick]   = id;
            slot_end[pick]  = end_pt;
            r.assigned      = REG_W'(pick);
        end else begin
            best     = 0;
            best_end = slot_end[0];
            for (int s = 1; s < NSLOTS; s++) begin
                if (best_end < slot_end[s]) begin
                    best     = s;
                    best_end = slot_end[s];
                end
            end
            if (best_end < end_pt) begin
                r.assigned     = SPILL_REG;
                r.self_spilled = 1'b1;
            end else begin
                r.victim_valid = 1'b1;
                r.victim_id    = slot_id[best];
                slot_id[best]  = id;
                slot_end[best] = end_pt;
                r.assigned     = REG_W'(best);
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NSLOTS; s++) begin
                slot_live[s] = 1'b0;
            end
            expected_allocs.delete();
        end else begin
            if (o_valid && i_ready) begin
                if (expected_allocs.size() == 0) begin
                    failures++;
                    $display("%0t: unexpected beat: reg %0d self %0b victim %0b id %h", $time,
                             o_assigned_reg, o_self_spilled, o_victim_valid, o_victim_id);
                end else begin
                    want = expected_allocs.pop_front();
                    if (o_assigned_reg !== want.assigned) begin
                        failures++;
                        $display("%0t: assigned_reg expected %0d actual %0d", $time,
                                 want.assigned, o_assigned_reg);
                    end
                    if (o_self_spilled !== want.self_spilled) begin
                        failures++;
                        $display("%0t: self_spilled expected %0b actual %0b", $time,
                                 want.self_spilled, o_self_spilled);
                    end
                    if (o_victim_valid !== want.victim_valid) begin
                        failures++;
                        $display("%0t: victim_valid expected %0b actual %0b", $time,
                                 want.victim_valid, o_victim_valid);
                    end
                    if (o_victim_id !== want.victim_id) begin
                        failures++;
                        $display("%0t: victim_id expected %h actual %h", $time,
                                 want.victim_id, o_victim_id);
                    end
                end
            end
            if (i_valid && o_ready) begin
                expected_allocs.push_back(
                    allocate_interval(i_interval_id, i_def_point, i_end_point));
            end
        end
        o_fail_count <= failures;
        o_pending    <= expected_allocs.size();
    end

endmodule

@@ verif/linear_scan_register_allocator_tb.sv @@
`timescale 1ns / 1ps
// Top of the allocator testbench: clock, reset, interval stimulus, ready stalls, verdict.
// Depends on lsra_pkg, the allocator RTL and lsra_checker.
module linear_scan_register_allocator_tb;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int PHASE_ITEMS    = 425;
    localparam int DRAIN_CYCLES   = 20;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [15:0] i_interval_id;
    logic [15:0] i_def_point;
    logic [15:0] i_end_point;
    logic        o_valid;
    logic        i_ready;
    logic [2:0]  o_assigned_reg;
    logic        o_self_spilled;
    logic        o_victim_valid;
    logic [15:0] o_victim_id;

    int          fail_count;
    int          pending;
    int          send_idle_pct;
    int          stall_pct;
    int          quiet_cycles;
    logic [15:0] def_cursor;

    linear_scan_register_allocator dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_interval_id  (i_interval_id),
        .i_def_point    (i_def_point),
        .i_end_point    (i_end_point),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_assigned_reg (o_assigned_reg),
        .o_self_spilled (o_self_spilled),
        .o_victim_valid (o_victim_valid),
        .o_victim_id    (o_victim_id)
    );

    lsra_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_interval_id  (i_interval_id),
        .i_def_point    (i_def_point),
        .i_end_point    (i_end_point),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_assigned_reg (o_assigned_reg),
        .o_self_spilled (o_self_spilled),
        .o_victim_valid (o_victim_valid),
        .o_victim_id    (o_victim_id),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            quiet_cycles <= 0;
        end else if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic issue_interval(input logic [15:0] id, input logic [15:0] def_pt,
                                  input logic [15:0] end_pt);
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_valid       <= 1'b1;
        i_interval_id <= id;
        i_def_point   <= def_pt;
        i_end_point   <= end_pt;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // Mostly intervals in definition order with mixed lifetimes; some pure noise.
    task automatic issue_random_interval();
        logic [15:0] end_pt;
        if ($urandom_range(99) < 15) begin
            issue_interval(16'($urandom), 16'($urandom), 16'($urandom));
        end else begin
            def_cursor = def_cursor + 16'($urandom_range(3));
            case ($urandom_range(9))
                0:       end_pt = 16'h0000;
                7, 8:    end_pt = def_cursor + 16'($urandom_range(200, 20));
                9:       end_pt = $urandom_range(1) ? 16'hFFFF
                                                    : def_cursor + 16'($urandom_range(3));
                default: end_pt = def_cursor + 16'($urandom_range(20, 1));
            endcase
            issue_interval(16'($urandom), def_cursor, end_pt);
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_ready       = 1'b0;
        i_interval_id = '0;
        i_def_point   = '0;
        i_end_point   = '0;
        send_idle_pct = 0;
        stall_pct     = 0;
        quiet_cycles  = 0;
        def_cursor    = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // fill every slot, with a tie on the furthest end
        issue_interval(16'd1, 16'd0, 16'd40);
        issue_interval(16'd2, 16'd0, 16'd70);
        issue_interval(16'd3, 16'd0, 16'd20);
        issue_interval(16'd4, 16'd0, 16'd70);
        issue_interval(16'd5, 16'd0, 16'd10);
        issue_interval(16'd6, 16'd0, 16'd30);
        issue_interval(16'd7, 16'd0, 16'd50);
        // strictly furthest new interval spills itself
        issue_interval(16'hFFFF, 16'd5, 16'd71);
        // equal end: lowest occupant with that end is evicted
        issue_interval(16'h1234, 16'd5, 16'd70);
        // occupant ending exactly at the definition frees its slot
        issue_interval(16'h0000, 16'd10, 16'hFFFF);
        // evict an occupant whose id is zero
        issue_interval(16'h0042, 16'd10, 16'h0000);
        issue_interval(16'hAAAA, 16'hFFFF, 16'hFFFF);
        issue_interval(16'h5555, 16'hFFFF, 16'h0000);
        issue_interval(16'h8000, 16'hFFFF, 16'h8000);
        issue_interval(16'h0001, 16'h0000, 16'h0000);
        issue_interval(16'h7FFF, 16'h0000, 16'hFFFF);
        issue_interval(16'hFFFE, 16'h0000, 16'hFFFF);
        issue_interval(16'h00FF, 16'h0000, 16'hFFFE);
        issue_interval(16'hFF00, 16'h0000, 16'hFFFF);
        issue_interval(16'h0F0F, 16'h0001, 16'h0001);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  stall_pct <= 0;  end
                1: begin send_idle_pct = 85; stall_pct <= 0;  end
                2: begin send_idle_pct = 0;  stall_pct <= 85; end
                default: begin send_idle_pct = 21; stall_pct <= 21; end
            endcase
            repeat (PHASE_ITEMS) issue_random_interval();
        end
        i_valid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
